/* design/yrd_pkg.sv */
package yrd_pkg;

  // fixed field widths
  localparam int VALUE_W   = 24;
  localparam int NC_W      = 8;
  localparam int THR_W     = 13;
  localparam int SCALE_W   = 16;
  localparam int CONF_W    = 13;
  localparam int CLASS_W   = 7;
  localparam int BOX_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // fraction bits of thresholds and scale
  localparam int THR_FRAC   = 12;
  localparam int SCALE_FRAC = 12;

  // doubled centers need two more bits than a raw value
  localparam int COORD_W = VALUE_W + 2;
  // coordinate times zero-extended scale
  localparam int PROD_W  = COORD_W + SCALE_W + 1;

  localparam int CONF_MAX = 4096;

  // parameter defaults
  localparam int DEF_MAX_CLASSES     = 128;
  localparam int DEF_VALUE_FRAC_BITS = 12;

  // register reset values
  localparam logic [NC_W-1:0]    RST_NUM_CLASSES = NC_W'(80);
  localparam logic [THR_W-1:0]   RST_CONF_THR    = THR_W'(1638);
  localparam logic [THR_W-1:0]   RST_SCORE_THR   = THR_W'(819);
  localparam logic [SCALE_W-1:0] RST_SCALE       = SCALE_W'(4096);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CLASSES = 2'd0,
    CFG_CONF_THR    = 2'd1,
    CFG_SCORE_THR   = 2'd2,
    CFG_SCALE       = 2'd3
  } cfg_index_e;

endpackage

/* design/yolo_row_decode.sv */
// channel   direction  handshake                  payload
// input     in         in_valid_i / in_ready_o    value_i
// result    out        out_valid_o / out_ready_i  class_index_o, confidence_o, box_*_o
// config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// One value is taken per cycle. Row values only update the held box, objectness and
// argmax; the last value of a row enters a four-stage path (snapshot, threshold check,
// scale multiply, truncate and saturate) and a passing row moves through the snapshot,
// check and product registers into the output register. Reset is asynchronous and
// clears row position, stage valids and loads the register defaults. A stalled output
// only blocks a row end when every stage ahead is full; mid-row values are always taken.
module yolo_row_decode import yrd_pkg::*; #(
  parameter int MAX_CLASSES     = DEF_MAX_CLASSES,
  parameter int VALUE_FRAC_BITS = DEF_VALUE_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CLASS_W-1:0]        class_index_o,
  output logic [CONF_W-1:0]         confidence_o,
  output logic signed [BOX_W-1:0]   box_left_o,
  output logic signed [BOX_W-1:0]   box_top_o,
  output logic signed [BOX_W-1:0]   box_width_o,
  output logic signed [BOX_W-1:0]   box_height_o
);

  localparam int POS_W  = $clog2(MAX_CLASSES + 5);
  localparam int CMP_W  = VALUE_W + THR_FRAC + VALUE_FRAC_BITS + 1;
  localparam int CONF_SHL = (VALUE_FRAC_BITS < THR_FRAC) ? THR_FRAC - VALUE_FRAC_BITS : 0;
  localparam int CONF_SHR = (VALUE_FRAC_BITS > THR_FRAC) ? VALUE_FRAC_BITS - THR_FRAC : 0;
  localparam int CONF_WW  = VALUE_W + CONF_SHL;

  // configuration registers
  logic [NC_W-1:0]    nc_q;
  logic [THR_W-1:0]   conf_thr_q;
  logic [THR_W-1:0]   score_thr_q;
  logic [SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q        <= RST_NUM_CLASSES;
      conf_thr_q  <= RST_CONF_THR;
      score_thr_q <= RST_SCORE_THR;
      scale_q     <= RST_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUM_CLASSES: nc_q        <= cfg_data_i[NC_W-1:0];
        CFG_CONF_THR:    conf_thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_SCORE_THR:   score_thr_q <= cfg_data_i[THR_W-1:0];
        CFG_SCALE:       scale_q     <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // row tracking state
  logic [POS_W-1:0]          pos_q, pos_d;
  logic signed [VALUE_W-1:0] box_q [4];
  logic signed [VALUE_W-1:0] obj_q;
  logic signed [VALUE_W-1:0] best_q, best_d;
  logic [CLASS_W-1:0]        idx_q, idx_d;

  logic [POS_W-1:0] eff_classes;
  logic [POS_W-1:0] last_pos;
  logic [POS_W-1:0] class_pos;
  logic             row_end;
  logic             accept;

  // stage control
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic en1, en2, en3, en_out;

  // effective class count and row end
  always_comb begin
    if (nc_q == '0) begin
      eff_classes = POS_W'(1);
    end else if (nc_q > MAX_CLASSES) begin
      eff_classes = POS_W'(MAX_CLASSES);
    end else begin
      eff_classes = POS_W'(nc_q);
    end
  end

  assign last_pos  = eff_classes + POS_W'(4);
  assign row_end   = (pos_q >= last_pos);
  assign class_pos = pos_q - POS_W'(5);

  assign en_out     = !out_valid_q || out_ready_i;
  assign en3        = !v3_q || en_out;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = !row_end || en1;
  assign accept     = in_valid_i && in_ready_o;

  // running argmax, first class always loads, ties keep the lower index
  always_comb begin
    best_d = best_q;
    idx_d  = idx_q;
    if (pos_q > POS_W'(4)) begin
      if (class_pos == '0 || value_i > best_q) begin
        best_d = value_i;
        idx_d  = CLASS_W'(class_pos);
      end
    end
  end

  assign pos_d = row_end ? '0 : pos_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (pos_q < POS_W'(4)) begin
        box_q[pos_q[1:0]] <= value_i;
      end
      if (pos_q == POS_W'(4)) begin
        obj_q <= value_i;
      end
      best_q <= best_d;
      idx_q  <= idx_d;
    end
  end

  // stage 1: row snapshot
  logic signed [VALUE_W-1:0] s1_box_q [4];
  logic signed [VALUE_W-1:0] s1_obj_q;
  logic signed [VALUE_W-1:0] s1_best_q;
  logic [CLASS_W-1:0]        s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (en1 && accept && row_end) begin
      s1_box_q  <= box_q;
      s1_obj_q  <= obj_q;
      s1_best_q <= best_d;
      s1_idx_q  <= idx_d;
    end
  end

  // threshold checks and box prep
  logic signed [CMP_W-1:0]   obj_al, thr_al, best_al, sthr_al;
  logic                      pass;
  logic [CONF_WW-1:0]        conf_wide;
  logic [CONF_W-1:0]         conf;
  logic signed [COORD_W-1:0] x2, y2, w_c, h_c;

  assign obj_al  = CMP_W'(s1_obj_q) <<< THR_FRAC;
  assign best_al = CMP_W'(s1_best_q) <<< THR_FRAC;
  assign thr_al  = $signed(CMP_W'(conf_thr_q) << VALUE_FRAC_BITS);
  assign sthr_al = $signed(CMP_W'(score_thr_q) << VALUE_FRAC_BITS);
  assign pass    = (obj_al >= thr_al) && (best_al > sthr_al);

  assign conf_wide = (CONF_WW'($unsigned(s1_obj_q)) << CONF_SHL) >> CONF_SHR;
  assign conf      = (conf_wide > CONF_WW'(CONF_MAX)) ? CONF_W'(CONF_MAX)
                                                       : conf_wide[CONF_W-1:0];

  assign w_c = COORD_W'(s1_box_q[2]);
  assign h_c = COORD_W'(s1_box_q[3]);
  assign x2  = (COORD_W'(s1_box_q[0]) <<< 1) - w_c;
  assign y2  = (COORD_W'(s1_box_q[1]) <<< 1) - h_c;

  // stage 2: checked row
  logic                      s2_pass_q;
  logic [CONF_W-1:0]         s2_conf_q;
  logic [CLASS_W-1:0]        s2_idx_q;
  logic signed [COORD_W-1:0] s2_x2_q, s2_y2_q, s2_w_q, s2_h_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_pass_q <= pass;
      s2_conf_q <= conf;
      s2_idx_q  <= s1_idx_q;
      s2_x2_q   <= x2;
      s2_y2_q   <= y2;
      s2_w_q    <= w_c;
      s2_h_q    <= h_c;
    end
  end

  // stage 3: scale products held in the lanes
  logic [CONF_W-1:0]        s3_conf_q;
  logic [CLASS_W-1:0]       s3_idx_q;
  logic signed [BOX_W-1:0]  left_c, top_c, width_c, height_c;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_conf_q <= s2_conf_q;
      s3_idx_q  <= s2_idx_q;
    end
  end

  yrd_box_scale #(.SHIFT(VALUE_FRAC_BITS + 1 + SCALE_FRAC)) u_left (
    .clk_i   (clk_i),
    .load_i  (en3),
    .coord_i (s2_x2_q),
    .scale_i (scale_q),
    .box_o   (left_c)
  );

  yrd_box_scale #(.SHIFT(VALUE_FRAC_BITS + 1 + SCALE_FRAC)) u_top (
    .clk_i   (clk_i),
    .load_i  (en3),
    .coord_i (s2_y2_q),
    .scale_i (scale_q),
    .box_o   (top_c)
  );

  yrd_box_scale #(.SHIFT(VALUE_FRAC_BITS + SCALE_FRAC)) u_width (
    .clk_i   (clk_i),
    .load_i  (en3),
    .coord_i (s2_w_q),
    .scale_i (scale_q),
    .box_o   (width_c)
  );

  yrd_box_scale #(.SHIFT(VALUE_FRAC_BITS + SCALE_FRAC)) u_height (
    .clk_i   (clk_i),
    .load_i  (en3),
    .coord_i (s2_h_q),
    .scale_i (scale_q),
    .box_o   (height_c)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (en_out) begin
      class_index_o <= s3_idx_q;
      confidence_o  <= s3_conf_q;
      box_left_o    <= left_c;
      box_top_o     <= top_c;
      box_width_o   <= width_c;
      box_height_o  <= height_c;
    end
  end

  // stage valids, failing rows drop out before the multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept && row_end;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q && s2_pass_q;
      end
      if (en_out) begin
        out_valid_q <= v3_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/yrd_box_scale.sv */
module yrd_box_scale import yrd_pkg::*; #(
  parameter int SHIFT = DEF_VALUE_FRAC_BITS + SCALE_FRAC
) (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic signed [COORD_W-1:0] coord_i,
  input  logic        [SCALE_W-1:0] scale_i,
  output logic signed [BOX_W-1:0]   box_o
);

  localparam logic [PROD_W-1:0] BIAS = (PROD_W'(1) << SHIFT) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] BOX_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] BOX_MIN = -PROD_W'(32768);

  logic signed [SCALE_W:0]    scale_s;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [PROD_W-1:0]   rounded;
  logic signed [PROD_W-1:0]   shifted;

  // coordinate times scale, registered
  assign scale_s = $signed({1'b0, scale_i});
  assign prod_d  = PROD_W'(coord_i) * PROD_W'(scale_s);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // shift toward zero: negative values get a bias before the arithmetic shift
  assign rounded = prod_q + (prod_q[PROD_W-1] ? $signed(BIAS) : '0);
  assign shifted = rounded >>> SHIFT;

  // saturate to 16-bit signed
  always_comb begin
    if (shifted > BOX_MAX) begin
      box_o = BOX_MAX[BOX_W-1:0];
    end else if (shifted < BOX_MIN) begin
      box_o = BOX_MIN[BOX_W-1:0];
    end else begin
      box_o = shifted[BOX_W-1:0];
    end
  end

endmodule
